@@ rtl/core/chacha20_stream_cipher_macros.svh @@
// Assertion helpers for the cipher top level (chacha20_stream_cipher).
// Each expects clk and rst_n in scope.
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication.
`define CC20_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define CC20_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/core/cc20_pkg.sv @@
`timescale 1ns / 1ps

package cc20_pkg;

    localparam int WORD_W          = 32;
    localparam int NUM_WORDS       = 16;
    localparam int WORD_IDX_W      = 4;
    localparam int NUM_DBL_ROUNDS  = 10;
    localparam int DBL_ROUND_W     = 4;
    localparam int BYTE_POS_W      = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_Q0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_Q1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_Q2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_Q3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CNT  = 3'd6;

    localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

    // Rotate amounts of the four quarter-round steps
    localparam int ROT_S0 = 16;
    localparam int ROT_S1 = 12;
    localparam int ROT_S2 = 8;
    localparam int ROT_S3 = 7;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] block_words_t;

    typedef struct packed {
        logic                  start;
        logic [WORD_IDX_W-1:0] ks_word_idx;
    } gen_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gen_stat_t;

endpackage

@@ rtl/core/cc20_qr_unit.sv @@
`timescale 1ns / 1ps

module cc20_qr_unit (
    input  logic [cc20_pkg::WORD_W-1:0] x,
    input  logic [cc20_pkg::WORD_W-1:0] y,
    input  logic [cc20_pkg::WORD_W-1:0] z,
    input  logic [1:0]                  step,
    output logic [cc20_pkg::WORD_W-1:0] sum,
    output logic [cc20_pkg::WORD_W-1:0] mixed
);
    import cc20_pkg::*;

    logic [WORD_W-1:0] mix_pre;

    assign sum     = x + y;
    assign mix_pre = z ^ sum;

    always_comb
    begin
        unique case (step)
            2'd0: mixed = (mix_pre << ROT_S0) | (mix_pre >> (WORD_W - ROT_S0));
            2'd1: mixed = (mix_pre << ROT_S1) | (mix_pre >> (WORD_W - ROT_S1));
            2'd2: mixed = (mix_pre << ROT_S2) | (mix_pre >> (WORD_W - ROT_S2));
            2'd3: mixed = (mix_pre << ROT_S3) | (mix_pre >> (WORD_W - ROT_S3));
            default: mixed = mix_pre;
        endcase
    end

endmodule

@@ rtl/core/cc20_block_gen.sv @@
`timescale 1ns / 1ps

module cc20_block_gen (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cc20_pkg::gen_ctrl_t         ctrl,
    input  cc20_pkg::block_words_t      init_words,
    output cc20_pkg::gen_stat_t         status,
    output logic [cc20_pkg::WORD_W-1:0] ks_word
);
    import cc20_pkg::*;

    typedef enum logic [2:0] {
        G_IDLE  = 3'b001,
        G_ROUND = 3'b010,
        G_FINAL = 3'b100
    } gen_state_t;

    gen_state_t gstate_reg, gstate_next;

    logic [1:0]             step_reg, step_next;
    logic [2:0]             qr_reg, qr_next;
    logic [DBL_ROUND_W-1:0] dr_reg, dr_next;
    logic [WORD_IDX_W-1:0]  fin_reg, fin_next;

    // Working state: row r, column c at index 4*r+c; quarter rounds run on column 0
    logic [WORD_W-1:0] w_reg [NUM_WORDS];
    logic [WORD_W-1:0] w_next [NUM_WORDS];
    logic [WORD_W-1:0] w_upd [NUM_WORDS];
    logic [WORD_W-1:0] ks_reg [NUM_WORDS];

    logic [1:0]        row_amt [4];
    logic [WORD_W-1:0] unit_x, unit_y, unit_z, unit_sum, unit_mixed;
    logic              last_step, last_col, last_diag, rounds_done;

    cc20_qr_unit u_qr (
        .x     (unit_x),
        .y     (unit_y),
        .z     (unit_z),
        .step  (step_reg),
        .sum   (unit_sum),
        .mixed (unit_mixed)
    );

    assign last_step   = (step_reg == 2'd3);
    assign last_col    = last_step && (qr_reg == 3'd3);
    assign last_diag   = last_step && (qr_reg == 3'd7);
    assign rounds_done = last_diag && (dr_reg == DBL_ROUND_W'(NUM_DBL_ROUNDS - 1));

    always_comb
    begin
        unit_x = w_reg[0];
        unit_y = init_words[fin_reg];
        unit_z = '0;
        if (gstate_reg == G_ROUND)
        begin
            if (!step_reg[0])
            begin
                unit_x = w_reg[0];
                unit_y = w_reg[4];
                unit_z = w_reg[12];
            end
            else
            begin
                unit_x = w_reg[8];
                unit_y = w_reg[12];
                unit_z = w_reg[4];
            end
        end
    end

    // Row rotate after each quarter round; the last one of a half round also
    // skews (or unskews) rows so diagonals line up in column 0
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            if (last_col)
                row_amt[r] = 2'(1 + r);
            else if (last_diag)
                row_amt[r] = 2'(1 - r);
            else
                row_amt[r] = 2'd1;
        end
    end

    always_comb
    begin
        gstate_next = gstate_reg;
        step_next   = step_reg;
        qr_next     = qr_reg;
        dr_next     = dr_reg;
        fin_next    = fin_reg;
        w_upd       = w_reg;
        w_next      = w_reg;
        unique case (gstate_reg)
            G_IDLE:
            begin
                if (ctrl.start)
                begin
                    for (int i = 0; i < NUM_WORDS; i++)
                        w_next[i] = init_words[i];
                    step_next   = '0;
                    qr_next     = '0;
                    dr_next     = '0;
                    gstate_next = G_ROUND;
                end
            end
            G_ROUND:
            begin
                if (!step_reg[0])
                begin
                    w_upd[0]  = unit_sum;
                    w_upd[12] = unit_mixed;
                end
                else
                begin
                    w_upd[8] = unit_sum;
                    w_upd[4] = unit_mixed;
                end
                if (last_step)
                begin
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++)
                            w_next[r * 4 + c] = w_upd[{2'(r), 2'(c) + row_amt[r]}];
                    qr_next = qr_reg + 3'd1;
                    if (qr_reg == 3'd7)
                        dr_next = dr_reg + DBL_ROUND_W'(1);
                    if (rounds_done)
                    begin
                        fin_next    = '0;
                        gstate_next = G_FINAL;
                    end
                end
                else
                begin
                    w_next = w_upd;
                end
                step_next = step_reg + 2'd1;
            end
            G_FINAL:
            begin
                // Shift the state down; word 0 meets its input word in the adder
                for (int i = 0; i < NUM_WORDS - 1; i++)
                    w_next[i] = w_reg[i + 1];
                fin_next = fin_reg + WORD_IDX_W'(1);
                if (fin_reg == WORD_IDX_W'(NUM_WORDS - 1))
                    gstate_next = G_IDLE;
            end
            default:
            begin
                gstate_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gstate_reg <= G_IDLE;
            step_reg   <= '0;
            qr_reg     <= '0;
            dr_reg     <= '0;
            fin_reg    <= '0;
        end
        else
        begin
            gstate_reg <= gstate_next;
            step_reg   <= step_next;
            qr_reg     <= qr_next;
            dr_reg     <= dr_next;
            fin_reg    <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (gstate_reg == G_FINAL)
        begin
            for (int i = 0; i < NUM_WORDS - 1; i++)
                ks_reg[i] <= ks_reg[i + 1];
            ks_reg[NUM_WORDS - 1] <= unit_sum;
        end
    end

    assign ks_word     = ks_reg[ctrl.ks_word_idx];
    assign status.busy = (gstate_reg != G_IDLE);
    assign status.done = (gstate_reg == G_FINAL) && (fin_reg == WORD_IDX_W'(NUM_WORDS - 1));

endmodule

@@ rtl/core/chacha20_stream_cipher.sv @@
// ChaCha20 stream cipher, one message byte per item.
// Input items on s_axis: tdata holds the message byte, tlast marks the final
// byte of a message. Output items on m_axis: tdata holds the byte XOR the
// keystream byte, tlast is passed along. Key, nonce and start counter come in
// through the cfg write port (cfg_we, cfg_index, cfg_data); the user must write
// them only while the block is idle, and the block itself does not enforce this.
// A start counter write also reloads the running block counter.
// An item that falls inside an existing keystream block goes from idle to the
// emit state, where its result is registered into the m_axis output register;
// the block then returns to idle for the next item. The first byte of each
// 64-byte block (and the first byte after tlast) waits for keystream generation:
// the quarter-round steps of ten double rounds, then the final addition of
// each of the 16 words, all through one shared add/xor/rotate unit. One item
// is in flight at a time; s_axis_tready is high only while idle.
// Reset clears configuration, block counter, byte position and the keystream-ready flag.
// A stalled receiver holds the output register; the next item is still taken,
// but its result waits until the output register frees.
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_macros.svh"

module chacha20_stream_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] plain_byte
    input  logic                            s_axis_tlast,   // last_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] cipher_byte
    output logic                            m_axis_tlast,   // last_out
    input  logic                            cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cc20_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_GEN  = 3'b010,
        ST_EMIT = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [63:0]           key_q0_reg, key_q1_reg, key_q2_reg, key_q3_reg, nonce_low_reg;
    logic [31:0]           nonce_high_reg, start_cnt_reg, blk_cnt_reg;
    logic [BYTE_POS_W-1:0] pos_reg;
    logic                  ks_ready_reg;
    logic [7:0]            byte_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_data_reg;
    logic                  out_last_reg;

    logic                  in_acc, out_free, emit_fire;
    logic [WORD_W-1:0]     ks_word;
    logic [7:0]            ks_byte;
    block_words_t          init_words;
    gen_ctrl_t             gen_ctrl;
    gen_stat_t             gen_status;

    assign init_words[0]  = SIGMA0;
    assign init_words[1]  = SIGMA1;
    assign init_words[2]  = SIGMA2;
    assign init_words[3]  = SIGMA3;
    assign init_words[4]  = key_q0_reg[31:0];
    assign init_words[5]  = key_q0_reg[63:32];
    assign init_words[6]  = key_q1_reg[31:0];
    assign init_words[7]  = key_q1_reg[63:32];
    assign init_words[8]  = key_q2_reg[31:0];
    assign init_words[9]  = key_q2_reg[63:32];
    assign init_words[10] = key_q3_reg[31:0];
    assign init_words[11] = key_q3_reg[63:32];
    assign init_words[12] = blk_cnt_reg;
    assign init_words[13] = nonce_low_reg[31:0];
    assign init_words[14] = nonce_low_reg[63:32];
    assign init_words[15] = nonce_high_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit_fire     = (state_reg == ST_EMIT) && out_free;

    assign gen_ctrl.start       = in_acc && !ks_ready_reg;
    assign gen_ctrl.ks_word_idx = pos_reg[BYTE_POS_W-1:2];

    cc20_block_gen u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (gen_ctrl),
        .init_words (init_words),
        .status     (gen_status),
        .ks_word    (ks_word)
    );

    assign ks_byte = ks_word[{pos_reg[1:0], 3'b000} +: 8];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ks_ready_reg ? ST_EMIT : ST_GEN;
            end
            ST_GEN:
            begin
                if (gen_status.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_q0_reg     <= '0;
            key_q1_reg     <= '0;
            key_q2_reg     <= '0;
            key_q3_reg     <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            start_cnt_reg  <= '0;
            blk_cnt_reg    <= '0;
            pos_reg        <= '0;
            ks_ready_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (gen_status.done)
                ks_ready_reg <= 1'b1;

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    pos_reg      <= '0;
                    ks_ready_reg <= 1'b0;
                    blk_cnt_reg  <= start_cnt_reg;
                end
                else if (pos_reg == BYTE_POS_W'(63))
                begin
                    pos_reg      <= '0;
                    ks_ready_reg <= 1'b0;
                    blk_cnt_reg  <= blk_cnt_reg + 32'd1;
                end
                else
                begin
                    pos_reg <= pos_reg + BYTE_POS_W'(1);
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_Q0:     key_q0_reg     <= cfg_data;
                    CFG_KEY_Q1:     key_q1_reg     <= cfg_data;
                    CFG_KEY_Q2:     key_q2_reg     <= cfg_data;
                    CFG_KEY_Q3:     key_q3_reg     <= cfg_data;
                    CFG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                    CFG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                    CFG_START_CNT:
                    begin
                        start_cnt_reg <= cfg_data[31:0];
                        blk_cnt_reg   <= cfg_data[31:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // Hold the accepted item until its result goes out
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (emit_fire)
        begin
            out_data_reg <= byte_reg ^ ks_byte;
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `CC20_ASSERT_NOW(a_pos_needs_ks, pos_reg != '0, ks_ready_reg, "byte position without keystream")
    `CC20_ASSERT_NEXT(a_ready_acc_emits, in_acc && ks_ready_reg, state_reg == ST_EMIT, "cached item not emitted")
    `CC20_ASSERT_NEXT(a_done_to_emit, gen_status.done, state_reg == ST_EMIT && ks_ready_reg, "block done lost")
    `CC20_ASSERT_NOW(a_busy_not_ready, gen_status.busy, !s_axis_tready, "input taken during generation")

endmodule
